/* rtl/vptz_pkg.sv */
// Shared types, codes and constants for the VISCA pan-tilt-zoom command and reply engine.
// Used by the command framer, the reply parser and the top level. No dependencies.
`default_nettype none

package vptz_pkg;

    // Reply packet storage.
    localparam int MaxPacket = 16;
    localparam int CountW    = $clog2(MaxPacket);
    localparam int LenW      = 5;

    // Longest command frame is the absolute position command.
    localparam int FrameMax  = 15;
    localparam int FrameIdxW = $clog2(FrameMax);

    // Bytes of a reply that the decoder looks at.
    localparam int DecodeBytes = 10;

    // Command codes.
    localparam logic [3:0] CMD_LEFT          = 4'd0;
    localparam logic [3:0] CMD_RIGHT         = 4'd1;
    localparam logic [3:0] CMD_UP            = 4'd2;
    localparam logic [3:0] CMD_DOWN          = 4'd3;
    localparam logic [3:0] CMD_STOP          = 4'd4;
    localparam logic [3:0] CMD_SETPOS_ACK    = 4'd5;
    localparam logic [3:0] CMD_SETPOS_DONE   = 4'd6;
    localparam logic [3:0] CMD_ZOOM_ACK      = 4'd7;
    localparam logic [3:0] CMD_ZOOM_DONE     = 4'd8;
    localparam logic [3:0] CMD_GET_POSITION  = 4'd9;
    localparam logic [3:0] CMD_GET_ZOOM      = 4'd10;
    localparam logic [3:0] CMD_GET_MAX_SPEED = 4'd11;

    // Result kinds.
    localparam logic [1:0] KIND_TX       = 2'd0;
    localparam logic [1:0] KIND_DONE     = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    // Awaited reply.
    localparam logic [1:0] WAIT_NONE     = 2'd0;
    localparam logic [1:0] WAIT_ACK      = 2'd1;
    localparam logic [1:0] WAIT_COMPLETE = 2'd2;
    localparam logic [1:0] WAIT_INQUIRY  = 2'd3;

    // Pending inquiry.
    localparam logic [1:0] INQ_NONE      = 2'd0;
    localparam logic [1:0] INQ_POSITION  = 2'd1;
    localparam logic [1:0] INQ_ZOOM      = 2'd2;
    localparam logic [1:0] INQ_MAX_SPEED = 2'd3;

    // Protocol bytes.
    localparam logic [7:0] HDR_BASE       = 8'h80;
    localparam logic [7:0] TERMINATOR     = 8'hFF;
    localparam logic [7:0] REPLY_ERROR    = 8'h60;
    localparam logic [7:0] REPLY_ACK_BIT  = 8'h40;
    localparam logic [7:0] REPLY_DONE_A   = 8'h51;
    localparam logic [7:0] REPLY_DONE_B   = 8'h52;
    localparam logic [7:0] REPLY_INQUIRY  = 8'h50;
    localparam logic [7:0] PAN_SPEED_MAX  = 8'h18;
    localparam logic [7:0] TILT_SPEED_MAX = 8'h14;

    typedef logic [MaxPacket-1:0][7:0] reply_buf_t;

    typedef struct packed {
        logic               action;
        logic [3:0]         command;
        logic [7:0]         move_speed;
        logic [7:0]         pan_speed;
        logic [7:0]         tilt_speed;
        logic signed [15:0] pan_target;
        logic signed [15:0] tilt_target;
        logic signed [16:0] zoom_target;
        logic [7:0]         rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [7:0]         tx_byte;
        logic               tx_last;
        logic [7:0]         error_code;
        logic [LenW-1:0]    reply_length;
        logic signed [15:0] pan_position;
        logic signed [15:0] tilt_position;
        logic signed [15:0] zoom_position;
        logic [7:0]         max_pan_speed;
        logic [7:0]         max_tilt_speed;
    } result_t;

    typedef struct packed {
        logic [7:0]           tx_byte;
        logic [FrameIdxW-1:0] len;
        logic [1:0]           awaited;
        logic [1:0]           inquiry;
    } frame_t;

    typedef struct packed {
        logic              produce;
        logic              clear_wait;
        logic [CountW-1:0] count_next;
        result_t           res;
    } rx_t;

endpackage

`default_nettype wire

/* rtl/vptz_tx_framer.sv */
// Command framer: gives the byte at one position of a VISCA command frame, the frame
// length and the reply the command waits for. Depends on vptz_pkg.
`default_nettype none

module vptz_tx_framer
    import vptz_pkg::*;
(
    input  wire item_t                item,
    input  wire logic [2:0]           camera_address,
    input  wire logic [FrameIdxW-1:0] byte_idx,
    output frame_t                    frame
);

    logic [FrameMax-1:0][7:0] seq;
    logic [7:0]               pan_clamped;
    logic [7:0]               tilt_clamped;
    logic [15:0]              zoom_value;
    logic [7:0]               header;

    always_comb begin
        header = HDR_BASE | {5'd0, camera_address};

        if (item.pan_speed > PAN_SPEED_MAX) begin
            pan_clamped = PAN_SPEED_MAX;
        end else if (item.pan_speed == 8'd0) begin
            pan_clamped = 8'd1;
        end else begin
            pan_clamped = item.pan_speed;
        end

        if (item.tilt_speed > TILT_SPEED_MAX) begin
            tilt_clamped = TILT_SPEED_MAX;
        end else if (item.tilt_speed == 8'd0) begin
            tilt_clamped = 8'd1;
        end else begin
            tilt_clamped = item.tilt_speed;
        end

        // The completion form of the zoom command sends a negative target as zero.
        if (item.command == CMD_ZOOM_DONE && item.zoom_target[16]) begin
            zoom_value = 16'd0;
        end else begin
            zoom_value = item.zoom_target[15:0];
        end

        seq           = '0;
        seq[0]        = header;
        frame.len     = '0;
        frame.awaited = WAIT_NONE;
        frame.inquiry = INQ_NONE;

        unique case (item.command)
            CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN, CMD_STOP: begin
                seq[1] = 8'h01;
                seq[2] = 8'h06;
                seq[3] = 8'h01;
                seq[4] = (item.command == CMD_LEFT || item.command == CMD_RIGHT)
                         ? item.move_speed : 8'h00;
                seq[5] = (item.command == CMD_UP || item.command == CMD_DOWN)
                         ? item.move_speed : 8'h00;
                seq[6] = (item.command == CMD_LEFT)  ? 8'h01 :
                         (item.command == CMD_RIGHT) ? 8'h02 : 8'h03;
                seq[7] = (item.command == CMD_UP)    ? 8'h01 :
                         (item.command == CMD_DOWN)  ? 8'h02 : 8'h03;
                seq[8] = TERMINATOR;
                frame.len     = FrameIdxW'(9);
                frame.awaited = WAIT_COMPLETE;
            end
            CMD_SETPOS_ACK, CMD_SETPOS_DONE: begin
                seq[1]  = 8'h01;
                seq[2]  = 8'h06;
                seq[3]  = 8'h02;
                seq[4]  = pan_clamped;
                seq[5]  = tilt_clamped;
                seq[6]  = {4'd0, item.pan_target[15:12]};
                seq[7]  = {4'd0, item.pan_target[11:8]};
                seq[8]  = {4'd0, item.pan_target[7:4]};
                seq[9]  = {4'd0, item.pan_target[3:0]};
                seq[10] = {4'd0, item.tilt_target[15:12]};
                seq[11] = {4'd0, item.tilt_target[11:8]};
                seq[12] = {4'd0, item.tilt_target[7:4]};
                seq[13] = {4'd0, item.tilt_target[3:0]};
                seq[14] = TERMINATOR;
                frame.len     = FrameIdxW'(15);
                frame.awaited = (item.command == CMD_SETPOS_ACK) ? WAIT_ACK : WAIT_COMPLETE;
            end
            CMD_ZOOM_ACK, CMD_ZOOM_DONE: begin
                seq[1] = 8'h01;
                seq[2] = 8'h04;
                seq[3] = 8'h47;
                seq[4] = {4'd0, zoom_value[15:12]};
                seq[5] = {4'd0, zoom_value[11:8]};
                seq[6] = {4'd0, zoom_value[7:4]};
                seq[7] = {4'd0, zoom_value[3:0]};
                seq[8] = TERMINATOR;
                frame.len     = FrameIdxW'(9);
                frame.awaited = (item.command == CMD_ZOOM_ACK) ? WAIT_ACK : WAIT_COMPLETE;
            end
            CMD_GET_POSITION: begin
                seq[1] = 8'h09;
                seq[2] = 8'h06;
                seq[3] = 8'h12;
                seq[4] = TERMINATOR;
                frame.len     = FrameIdxW'(5);
                frame.awaited = WAIT_INQUIRY;
                frame.inquiry = INQ_POSITION;
            end
            CMD_GET_ZOOM: begin
                seq[1] = 8'h09;
                seq[2] = 8'h04;
                seq[3] = 8'h47;
                seq[4] = TERMINATOR;
                frame.len     = FrameIdxW'(5);
                frame.awaited = WAIT_INQUIRY;
                frame.inquiry = INQ_ZOOM;
            end
            CMD_GET_MAX_SPEED: begin
                seq[1] = 8'h09;
                seq[2] = 8'h06;
                seq[3] = 8'h11;
                seq[4] = TERMINATOR;
                frame.len     = FrameIdxW'(5);
                frame.awaited = WAIT_INQUIRY;
                frame.inquiry = INQ_MAX_SPEED;
            end
            default: begin
                // Unknown commands send nothing; a zero length marks them.
                frame.len = '0;
            end
        endcase

        frame.tx_byte = seq[byte_idx];
    end

endmodule

`default_nettype wire

/* rtl/vptz_rx_parser.sv */
// Reply parser: takes one received byte against the gathered packet and the awaited
// reply, and gives the result, the next byte count and whether the wait ends. Uses vptz_pkg.
`default_nettype none

module vptz_rx_parser
    import vptz_pkg::*;
(
    input  wire reply_buf_t        reply_buf,
    input  wire logic [CountW-1:0] reply_count,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [1:0]        awaited,
    input  wire logic [1:0]        inquiry,
    output rx_t                    rx
);

    logic [CountW:0]               n;
    logic                          overflow;
    logic                          match;
    logic [DecodeBytes-1:0][7:0]   pkt;

    // Two received bytes each carry a nibble, but the whole bytes are merged.
    function automatic logic [15:0] join_nibbles(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c, input logic [7:0] d);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {a[3:0], 4'd0} | b;
        lo = {c[3:0], 4'd0} | d;
        return {hi, lo};
    endfunction

    always_comb begin
        n        = {1'b0, reply_count} + (CountW+1)'(1);
        overflow = (n == (CountW+1)'(MaxPacket));

        // Packet view with the current byte in place; bytes past the packet read as zero.
        for (int i = 0; i < DecodeBytes; i++) begin
            if ((CountW+1)'(i) < n) begin
                pkt[i] = ((CountW+1)'(i) == {1'b0, reply_count}) ? rx_byte : reply_buf[i];
            end else begin
                pkt[i] = 8'd0;
            end
        end

        unique case (awaited)
            WAIT_ACK:      match = (pkt[1] & REPLY_ACK_BIT) == REPLY_ACK_BIT;
            WAIT_COMPLETE: match = (pkt[1] == REPLY_DONE_A) || (pkt[1] == REPLY_DONE_B);
            WAIT_INQUIRY:  match = (pkt[1] == REPLY_INQUIRY);
            default:       match = 1'b0;
        endcase

        rx            = '0;
        rx.count_next = '0;

        priority if (overflow) begin
            rx.produce         = 1'b1;
            rx.res.result_kind = KIND_OVERFLOW;
        end else if (rx_byte != TERMINATOR) begin
            rx.count_next = n[CountW-1:0];
        end else if (awaited != WAIT_NONE && pkt[1] == REPLY_ERROR) begin
            rx.produce          = 1'b1;
            rx.clear_wait       = 1'b1;
            rx.res.result_kind  = KIND_ERROR;
            rx.res.error_code   = pkt[2];
            rx.res.reply_length = n[LenW-1:0];
        end else if (awaited != WAIT_NONE && match) begin
            rx.produce          = 1'b1;
            rx.clear_wait       = 1'b1;
            rx.res.result_kind  = KIND_DONE;
            rx.res.reply_length = n[LenW-1:0];
            if (awaited == WAIT_INQUIRY) begin
                unique case (inquiry)
                    INQ_POSITION: begin
                        rx.res.pan_position  = join_nibbles(pkt[2], pkt[3], pkt[4], pkt[5]);
                        rx.res.tilt_position = join_nibbles(pkt[6], pkt[7], pkt[8], pkt[9]);
                    end
                    INQ_ZOOM: begin
                        rx.res.zoom_position = join_nibbles(pkt[2], pkt[3], pkt[4], pkt[5]);
                    end
                    INQ_MAX_SPEED: begin
                        rx.res.max_pan_speed  = pkt[2];
                        rx.res.max_tilt_speed = pkt[3];
                    end
                    default: begin
                        rx.res.reply_length = n[LenW-1:0];
                    end
                endcase
            end
        end else begin
            // Packet closed but nothing matched: dropped without a result.
            rx.count_next = '0;
        end
    end

endmodule

`default_nettype wire

/* rtl/visca_ptz_command_reply_engine_unit.sv */
// Top level of the VISCA pan-tilt-zoom command and reply engine.
// Depends on vptz_pkg, vptz_tx_framer and vptz_rx_parser.
//
// Usage. The slave stream carries one item per beat. s_tuser selects the item kind:
// 0 issues a command, 1 delivers one byte received from the camera. A command item
// produces its framed bytes on the master stream, one beat per byte with result kind
// "transmit" in m_tuser and m_tlast on the closing 0xFF; it also records the reply the
// command waits for. Received bytes gather in a sixteen-entry packet buffer until 0xFF.
// A closed packet gives one beat: camera error, reply done (with decoded inquiry
// values) or nothing when it does not match. Reaching sixteen gathered bytes gives one
// overflow beat and restarts the count while keeping the wait.
// Timing. An accepted item sits in an input register; its results are built there by
// short logic and loaded into the output register, from which the master stream
// offers them. A command of L bytes (5, 9 or 15) holds the input register until its
// last byte loads; received bytes and unknown commands leave it as soon as any result
// they give loads, so byte streams run at one beat per cycle while the output register
// is free. The input register is freed in the same cycle as its last result loads, so
// the next item enters then.
// When the receiver stalls, the output register holds its beat and the input side
// stalls once the pending item needs the output register.
// Reset (aresetn low, synchronous) sets the camera address to 1, clears the wait and
// the byte count and empties both registers. cfg_data writes the 3-bit camera address
// and is accepted in every cycle; write it only while the engine is idle.
`default_nettype none

module visca_ptz_command_reply_engine_unit
    import vptz_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration: camera address.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data,

    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata from bit 0: command[3:0], move_speed[11:4], pan_speed[19:12],
    // tilt_speed[27:20], pan_target[43:28], tilt_target[59:44], zoom_target[76:60],
    // rx_byte[84:77], zero fill[87:85].
    input  wire logic [87:0] s_tdata,
    // s_tuser: action.
    input  wire logic        s_tuser,

    // Results.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata from bit 0: tx_byte[7:0], error_code[15:8], reply_length[20:16],
    // pan_position[36:21], tilt_position[52:37], zoom_position[68:53],
    // max_pan_speed[76:69], max_tilt_speed[84:77], zero fill[87:85].
    output logic [87:0]      m_tdata,
    // m_tuser: result_kind.
    output logic [1:0]       m_tuser,
    // m_tlast: tx_last.
    output logic             m_tlast
);

    // Configuration and reply state.
    logic [2:0]           cam_addr_reg;
    reply_buf_t           reply_buf_reg;
    logic [CountW-1:0]    count_reg,   count_next;
    logic [1:0]           awaited_reg, awaited_next;
    logic [1:0]           inquiry_reg, inquiry_next;
    logic                 buf_write;

    // Input register and frame position.
    logic                 item_valid_reg, item_valid_next;
    item_t                item_reg;
    item_t                s_item;
    logic [FrameIdxW-1:0] idx_reg, idx_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic                 s_accept;
    logic                 out_free;
    logic                 out_load;
    logic                 item_retire;

    frame_t               frame;
    rx_t                  rx;

    assign cfg_ready = 1'b1;

    always_comb begin
        s_item.action      = s_tuser;
        s_item.command     = s_tdata[3:0];
        s_item.move_speed  = s_tdata[11:4];
        s_item.pan_speed   = s_tdata[19:12];
        s_item.tilt_speed  = s_tdata[27:20];
        s_item.pan_target  = s_tdata[43:28];
        s_item.tilt_target = s_tdata[59:44];
        s_item.zoom_target = s_tdata[76:60];
        s_item.rx_byte     = s_tdata[84:77];
    end

    vptz_tx_framer u_framer (
        .item           (item_reg),
        .camera_address (cam_addr_reg),
        .byte_idx       (idx_reg),
        .frame          (frame)
    );

    vptz_rx_parser u_parser (
        .reply_buf   (reply_buf_reg),
        .reply_count (count_reg),
        .rx_byte     (item_reg.rx_byte),
        .awaited     (awaited_reg),
        .inquiry     (inquiry_reg),
        .rx          (rx)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !item_valid_reg || item_retire;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        item_retire  = 1'b0;
        out_load     = 1'b0;
        out_next     = out_reg;
        buf_write    = 1'b0;
        count_next   = count_reg;
        awaited_next = awaited_reg;
        inquiry_next = inquiry_reg;

        if (item_valid_reg) begin
            if (item_reg.action) begin
                // Received byte: state moves on when the item leaves, with its result if any.
                if (!rx.produce) begin
                    item_retire = 1'b1;
                end else if (out_free) begin
                    item_retire = 1'b1;
                    out_load    = 1'b1;
                    out_next    = rx.res;
                end
                if (item_retire) begin
                    buf_write  = 1'b1;
                    count_next = rx.count_next;
                    if (rx.clear_wait) begin
                        awaited_next = WAIT_NONE;
                        inquiry_next = INQ_NONE;
                    end
                end
            end else begin
                if (frame.len == '0) begin
                    item_retire = 1'b1;
                end else if (out_free) begin
                    out_load             = 1'b1;
                    out_next             = '0;
                    out_next.result_kind = KIND_TX;
                    out_next.tx_byte     = frame.tx_byte;
                    out_next.tx_last     = (idx_reg == frame.len - FrameIdxW'(1));
                    item_retire          = out_next.tx_last;
                end
                // A new known command replaces any wait and drops a partly gathered packet.
                if (item_retire && frame.len != '0) begin
                    awaited_next = frame.awaited;
                    inquiry_next = frame.inquiry;
                    count_next   = '0;
                end
            end
        end

        if (s_accept) begin
            item_valid_next = 1'b1;
            idx_next        = '0;
        end else begin
            item_valid_next = item_valid_reg && !item_retire;
            idx_next        = (out_load && !item_retire) ? idx_reg + FrameIdxW'(1) : idx_reg;
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_addr_reg   <= 3'd1;
            count_reg      <= '0;
            awaited_reg    <= WAIT_NONE;
            inquiry_reg    <= INQ_NONE;
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cam_addr_reg <= cfg_data;
            end
            count_reg      <= count_next;
            awaited_reg    <= awaited_next;
            inquiry_reg    <= inquiry_next;
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_item;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
        if (buf_write) begin
            reply_buf_reg[count_reg] <= item_reg.rx_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.result_kind;
    assign m_tlast  = out_reg.tx_last;
    assign m_tdata  = {3'd0,
                       out_reg.max_tilt_speed,
                       out_reg.max_pan_speed,
                       out_reg.zoom_position,
                       out_reg.tilt_position,
                       out_reg.pan_position,
                       out_reg.reply_length,
                       out_reg.error_code,
                       out_reg.tx_byte};

endmodule

`default_nettype wire

/* tb/sv/visca_ptz_command_reply_engine_unit_tb.sv */
// Self-checking testbench for the VISCA pan-tilt-zoom command and reply engine.
// It predicts command frames and reply outcomes with its own engine model and checks them.
// Depends on vptz_pkg and visca_ptz_command_reply_engine_unit.
`default_nettype none

module visca_ptz_command_reply_engine_unit_tb;
    import vptz_pkg::*;

    localparam int TimeLimit    = 2_000_000;
    localparam int SettleCycles = 10;
    localparam int HoldCycles   = 200;
    localparam int RandomItems  = 8;

    // Protocol bytes that sit between the header and the payload of a frame.
    localparam logic [7:0] CAT_COMMAND  = 8'h01;
    localparam logic [7:0] CAT_INQUIRY  = 8'h09;
    localparam logic [7:0] GRP_PAN_TILT = 8'h06;
    localparam logic [7:0] GRP_CAMERA   = 8'h04;
    localparam logic [7:0] OP_DRIVE     = 8'h01;
    localparam logic [7:0] OP_ABSOLUTE  = 8'h02;
    localparam logic [7:0] OP_ZOOM      = 8'h47;
    localparam logic [7:0] OP_POS_INQ   = 8'h12;
    localparam logic [7:0] OP_SPEED_INQ = 8'h11;
    localparam logic [7:0] PAN_LEFT     = 8'h01;
    localparam logic [7:0] PAN_RIGHT    = 8'h02;
    localparam logic [7:0] TILT_UP      = 8'h01;
    localparam logic [7:0] TILT_DOWN    = 8'h02;
    localparam logic [7:0] AXIS_STOP    = 8'h03;
    localparam logic [7:0] REPLY_ACK    = 8'h41;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    visca_ptz_command_reply_engine_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Engine model state, kept apart from the block under test.
    logic [2:0]  cam_addr  = 3'd1;
    logic [7:0]  rx_store[MaxPacket];
    int unsigned rx_count  = 0;
    logic [1:0]  wait_kind = WAIT_NONE;
    logic [1:0]  inq_kind  = INQ_NONE;
    result_t     expected_beats[$];

    // Run bookkeeping.
    int failures      = 0;
    int items_sent    = 0;
    int beats_checked = 0;
    int done_seen     = 0;
    int error_seen    = 0;
    int overflow_seen = 0;

    // Handshake pressure knobs: set by the main sequence, hold_off by the hold-off process.
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    logic        hold_off       = 1'b0;
    event        stall_request;

    // ------------------------------------------------------------------
    // Engine model.
    // ------------------------------------------------------------------

    // Bytes at or past the packet length read as zero.
    function automatic logic [7:0] rx_byte_at(int unsigned i, int unsigned n);
        return (i < n && i < MaxPacket) ? rx_store[i] : 8'h00;
    endfunction

    // Four reply bytes folded into a 16-bit word: each half is (low nibble << 4) | next byte.
    function automatic logic [15:0] nibble_word(int unsigned n, int unsigned first);
        logic [7:0] a, b, c, d;
        a = rx_byte_at(first, n);
        b = rx_byte_at(first + 1, n);
        c = rx_byte_at(first + 2, n);
        d = rx_byte_at(first + 3, n);
        return {({a[3:0], 4'h0} | b), ({c[3:0], 4'h0} | d)};
    endfunction

    function automatic logic [7:0] clamp_speed(logic [7:0] s, logic [7:0] top);
        if (s > top) return top;
        if (s == 8'h00) return 8'h01;
        return s;
    endfunction

    function automatic result_t blank_result(logic [1:0] kind);
        result_t r;
        r = '0;
        r.result_kind = kind;
        return r;
    endfunction

    // A closed packet: camera error, matching reply, or silently dropped.
    function automatic void close_packet(int unsigned n);
        logic [7:0] b1;
        result_t    r;
        logic       hit;
        b1 = rx_byte_at(1, n);
        if (wait_kind == WAIT_NONE) return;
        if (b1 == REPLY_ERROR) begin
            r = blank_result(KIND_ERROR);
            r.error_code = rx_byte_at(2, n);
            r.reply_length = 5'(n);
            expected_beats.push_back(r);
            wait_kind = WAIT_NONE;
            inq_kind = INQ_NONE;
            return;
        end
        case (wait_kind)
            WAIT_ACK:      hit = (b1 & REPLY_ACK_BIT) == REPLY_ACK_BIT;
            WAIT_COMPLETE: hit = (b1 == REPLY_DONE_A) || (b1 == REPLY_DONE_B);
            default:       hit = (b1 == REPLY_INQUIRY);
        endcase
        if (!hit) return;
        r = blank_result(KIND_DONE);
        r.reply_length = 5'(n);
        if (wait_kind == WAIT_INQUIRY) begin
            case (inq_kind)
                INQ_POSITION: begin
                    r.pan_position = nibble_word(n, 2);
                    r.tilt_position = nibble_word(n, 6);
                end
                INQ_ZOOM: r.zoom_position = nibble_word(n, 2);
                INQ_MAX_SPEED: begin
                    r.max_pan_speed = rx_byte_at(2, n);
                    r.max_tilt_speed = rx_byte_at(3, n);
                end
                default: ;
            endcase
        end
        expected_beats.push_back(r);
        wait_kind = WAIT_NONE;
        inq_kind = INQ_NONE;
    endfunction

    // Works out the result beats that one accepted item causes.
    function automatic void predict_engine(item_t it);
        logic [7:0]  frame[$];
        logic [31:0] nib_src;
        int          nib_cnt;
        logic [16:0] z;
        logic [1:0]  next_wait, next_inq;
        int unsigned n;
        result_t     r;

        if (it.action) begin
            n = rx_count + 1;
            if (rx_count < MaxPacket) rx_store[rx_count] = it.rx_byte;
            if (n >= MaxPacket) begin
                // Overflow keeps the wait and restarts gathering.
                rx_count = 0;
                expected_beats.push_back(blank_result(KIND_OVERFLOW));
                return;
            end
            if (it.rx_byte != TERMINATOR) begin
                rx_count = n;
                return;
            end
            rx_count = 0;
            close_packet(n);
            return;
        end

        // Unknown commands leave everything as it was, partial packet included.
        if (it.command > CMD_GET_MAX_SPEED) return;

        nib_src = '0;
        nib_cnt = 0;
        next_inq = INQ_NONE;
        frame.push_back(HDR_BASE | {5'b0, cam_addr});
        case (it.command)
            CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN, CMD_STOP: begin
                frame.push_back(CAT_COMMAND);
                frame.push_back(GRP_PAN_TILT);
                frame.push_back(OP_DRIVE);
                frame.push_back((it.command == CMD_LEFT || it.command == CMD_RIGHT) ?
                                it.move_speed : 8'h00);
                frame.push_back((it.command == CMD_UP || it.command == CMD_DOWN) ?
                                it.move_speed : 8'h00);
                frame.push_back(it.command == CMD_LEFT  ? PAN_LEFT :
                                it.command == CMD_RIGHT ? PAN_RIGHT : AXIS_STOP);
                frame.push_back(it.command == CMD_UP   ? TILT_UP :
                                it.command == CMD_DOWN ? TILT_DOWN : AXIS_STOP);
                next_wait = WAIT_COMPLETE;
            end
            CMD_SETPOS_ACK, CMD_SETPOS_DONE: begin
                frame.push_back(CAT_COMMAND);
                frame.push_back(GRP_PAN_TILT);
                frame.push_back(OP_ABSOLUTE);
                frame.push_back(clamp_speed(it.pan_speed, PAN_SPEED_MAX));
                frame.push_back(clamp_speed(it.tilt_speed, TILT_SPEED_MAX));
                nib_src = {it.pan_target, it.tilt_target};
                nib_cnt = 8;
                next_wait = (it.command == CMD_SETPOS_ACK) ? WAIT_ACK : WAIT_COMPLETE;
            end
            CMD_ZOOM_ACK, CMD_ZOOM_DONE: begin
                z = it.zoom_target;
                // The completion form never sends a negative zoom.
                if (it.command == CMD_ZOOM_DONE && z[16]) z = '0;
                frame.push_back(CAT_COMMAND);
                frame.push_back(GRP_CAMERA);
                frame.push_back(OP_ZOOM);
                nib_src = {16'h0000, z[15:0]};
                nib_cnt = 4;
                next_wait = (it.command == CMD_ZOOM_ACK) ? WAIT_ACK : WAIT_COMPLETE;
            end
            default: begin
                frame.push_back(CAT_INQUIRY);
                if (it.command == CMD_GET_POSITION) begin
                    frame.push_back(GRP_PAN_TILT);
                    frame.push_back(OP_POS_INQ);
                    next_inq = INQ_POSITION;
                end else if (it.command == CMD_GET_ZOOM) begin
                    frame.push_back(GRP_CAMERA);
                    frame.push_back(OP_ZOOM);
                    next_inq = INQ_ZOOM;
                end else begin
                    frame.push_back(GRP_PAN_TILT);
                    frame.push_back(OP_SPEED_INQ);
                    next_inq = INQ_MAX_SPEED;
                end
                next_wait = WAIT_INQUIRY;
            end
        endcase
        for (int k = nib_cnt - 1; k >= 0; k--) frame.push_back({4'h0, nib_src[4*k +: 4]});
        frame.push_back(TERMINATOR);

        // A new command replaces any pending wait and discards a partial packet.
        wait_kind = next_wait;
        inq_kind = next_inq;
        rx_count = 0;

        for (int i = 0; i < frame.size(); i++) begin
            r = blank_result(KIND_TX);
            r.tx_byte = frame[i];
            r.tx_last = (i == frame.size() - 1);
            expected_beats.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: receiver stalls and the beat checker.
    // ------------------------------------------------------------------

    // The long hold-off runs in its own process and counts its own cycles.
    initial begin
        forever begin
            @(stall_request);
            hold_off <= 1'b1;
            repeat (HoldCycles) @(negedge aclk);
            hold_off <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin : beat_check
        result_t seen, want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.result_kind    = m_tuser;
            seen.tx_byte        = m_tdata[7:0];
            seen.tx_last        = m_tlast;
            seen.error_code     = m_tdata[15:8];
            seen.reply_length   = m_tdata[20:16];
            seen.pan_position   = m_tdata[36:21];
            seen.tilt_position  = m_tdata[52:37];
            seen.zoom_position  = m_tdata[68:53];
            seen.max_pan_speed  = m_tdata[76:69];
            seen.max_tilt_speed = m_tdata[84:77];
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: kind %0d, data 0x%0h",
                       m_tuser, m_tdata);
                failures++;
            end else begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (want.result_kind == KIND_DONE) done_seen++;
                if (want.result_kind == KIND_ERROR) error_seen++;
                if (want.result_kind == KIND_OVERFLOW) overflow_seen++;
                check_field("result_kind", 32'(want.result_kind), 32'(seen.result_kind));
                check_field("tx_byte", 32'(want.tx_byte), 32'(seen.tx_byte));
                check_field("tx_last", 32'(want.tx_last), 32'(seen.tx_last));
                check_field("error_code", 32'(want.error_code), 32'(seen.error_code));
                check_field("reply_length", 32'(want.reply_length), 32'(seen.reply_length));
                check_field("pan_position", 32'(want.pan_position), 32'(seen.pan_position));
                check_field("tilt_position", 32'(want.tilt_position),
                            32'(seen.tilt_position));
                check_field("zoom_position", 32'(want.zoom_position),
                            32'(seen.zoom_position));
                check_field("max_pan_speed", 32'(want.max_pan_speed),
                            32'(seen.max_pan_speed));
                check_field("max_tilt_speed", 32'(want.max_tilt_speed),
                            32'(seen.max_tilt_speed));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    function automatic item_t random_item();
        item_t it;
        it.action      = 1'($urandom);
        it.command     = 4'($urandom);
        it.move_speed  = 8'($urandom);
        // Half the speeds land near the clamp limits.
        it.pan_speed   = $urandom_range(1) ? 8'($urandom_range(30)) : 8'($urandom);
        it.tilt_speed  = $urandom_range(1) ? 8'($urandom_range(30)) : 8'($urandom);
        it.pan_target  = 16'($urandom);
        it.tilt_target = 16'($urandom);
        it.zoom_target = 17'($urandom);
        it.rx_byte     = 8'($urandom);
        return it;
    endfunction

    function automatic item_t command_item(logic [3:0] cmd);
        item_t it;
        it = random_item();
        it.action = 1'b0;
        it.command = cmd;
        return it;
    endfunction

    // Offers one beat from a falling edge and returns at the falling edge after its
    // handshake. tvalid stays high on return, so back-to-back beats leave no idle gap.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {3'b000, it.rx_byte, it.zoom_target, it.tilt_target, it.pan_target,
                     it.tilt_speed, it.pan_speed, it.move_speed, it.command};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_engine(it);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic issue_command(input logic [3:0] cmd);
        send_item(command_item(cmd));
    endtask

    task automatic send_packet(input logic [7:0] pkt[$]);
        item_t it;
        foreach (pkt[i]) begin
            it = random_item();
            it.action = 1'b1;
            it.rx_byte = pkt[i];
            send_item(it);
        end
    endtask

    // Waits until every expected beat has come, then lets items with no result
    // finish inside the engine.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_address(input logic [2:0] addr);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cam_addr = addr;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Every command with field extremes, clamp edges and unknown codes.
    task automatic test_directed_commands();
        item_t it;
        it = command_item(CMD_LEFT);   it.move_speed = 8'h00; send_item(it);
        it = command_item(CMD_RIGHT);  it.move_speed = 8'hFF; send_item(it);
        it = command_item(CMD_UP);     it.move_speed = 8'h80; send_item(it);
        it = command_item(CMD_DOWN);   it.move_speed = 8'h01; send_item(it);
        it = command_item(CMD_STOP);   it.move_speed = 8'h55; send_item(it);
        it = command_item(CMD_SETPOS_ACK);
        it.pan_speed = 8'h00; it.tilt_speed = 8'h00;
        it.pan_target = 16'h8000; it.tilt_target = 16'h7FFF;
        send_item(it);
        it = command_item(CMD_SETPOS_DONE);
        it.pan_speed = 8'hFF; it.tilt_speed = 8'hFF;
        it.pan_target = 16'hFFFF; it.tilt_target = 16'h0000;
        send_item(it);
        it = command_item(CMD_SETPOS_ACK);
        it.pan_speed = 8'd25; it.tilt_speed = 8'd21;
        send_item(it);
        it = command_item(CMD_SETPOS_DONE);
        it.pan_speed = 8'd24; it.tilt_speed = 8'd20;
        send_item(it);
        // Negative zoom goes out as its low bits in the acknowledge form only.
        it = command_item(CMD_ZOOM_ACK);  it.zoom_target = 17'h1FFFF; send_item(it);
        it = command_item(CMD_ZOOM_DONE); it.zoom_target = 17'h1FFFF; send_item(it);
        it = command_item(CMD_ZOOM_DONE); it.zoom_target = 17'h10000; send_item(it);
        it = command_item(CMD_ZOOM_DONE); it.zoom_target = 17'h0FFFF; send_item(it);
        issue_command(CMD_GET_POSITION);
        issue_command(CMD_GET_ZOOM);
        issue_command(CMD_GET_MAX_SPEED);
        issue_command(4'd12);
        issue_command(4'd15);
        wait_idle();
    endtask

    // Reply handling: decoding, matching rules, drops, errors, overflow.
    task automatic test_reply_cases();
        logic [7:0] pkt[$];
        issue_command(CMD_GET_POSITION);
        pkt = {8'h90, REPLY_INQUIRY, 8'h0F, 8'h0F, 8'h0F, 8'h0F,
               8'h00, 8'h00, 8'h00, 8'h01, TERMINATOR};
        send_packet(pkt);
        // Nothing is awaited now, so this acknowledge is dropped.
        pkt = {8'h90, REPLY_ACK, TERMINATOR};
        send_packet(pkt);
        // A short inquiry reply reads zero past its end.
        issue_command(CMD_GET_ZOOM);
        pkt = {8'h90, REPLY_INQUIRY, 8'h01, TERMINATOR};
        send_packet(pkt);
        // A completion reply also satisfies an acknowledge wait.
        issue_command(CMD_ZOOM_ACK);
        pkt = {8'h90, REPLY_DONE_A, TERMINATOR};
        send_packet(pkt);
        // An acknowledge does not end a completion wait; the error does.
        issue_command(CMD_SETPOS_DONE);
        pkt = {8'h90, REPLY_ACK, TERMINATOR};
        send_packet(pkt);
        pkt = {8'h90, REPLY_ERROR, 8'h02, TERMINATOR};
        send_packet(pkt);
        // A new command throws away a partly gathered reply.
        issue_command(CMD_GET_MAX_SPEED);
        pkt = {8'h90, REPLY_INQUIRY};
        send_packet(pkt);
        issue_command(CMD_GET_MAX_SPEED);
        pkt = {8'h90, REPLY_INQUIRY, PAN_SPEED_MAX, TILT_SPEED_MAX, TERMINATOR};
        send_packet(pkt);
        // Sixteen bytes overflow even when the last is a terminator; the wait survives.
        issue_command(CMD_STOP);
        pkt.delete();
        for (int i = 0; i < MaxPacket - 1; i++) pkt.push_back(8'(i));
        pkt.push_back(TERMINATOR);
        send_packet(pkt);
        pkt = {8'h90, REPLY_DONE_B, TERMINATOR};
        send_packet(pkt);
        wait_idle();
    endtask

    // Address register at both extremes and one value between.
    task automatic test_address_settings();
        logic [7:0] pkt[$];
        write_address(3'd0);
        issue_command(CMD_LEFT);
        pkt = {8'h90, REPLY_DONE_A, TERMINATOR};
        send_packet(pkt);
        write_address(3'd7);
        issue_command(CMD_GET_ZOOM);
        pkt = {8'hF0, REPLY_INQUIRY, 8'h08, 8'h00, 8'h00, 8'h00, TERMINATOR};
        send_packet(pkt);
        write_address(3'($urandom_range(6, 2)));
        issue_command(CMD_SETPOS_ACK);
        pkt = {8'h90, REPLY_ACK, TERMINATOR};
        send_packet(pkt);
        wait_idle();
    endtask

    // The receiver holds off while long frames keep coming, so the engine
    // fills and must stall its input.
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        -> stall_request;
        repeat (6) issue_command(CMD_SETPOS_DONE);
        wait_idle();
    endtask

    // One command followed, most of the time, by a plausible reply stream.
    task automatic random_exchange();
        logic [3:0]  cmd;
        logic [7:0]  hdr;
        logic [7:0]  pkt[$];
        int unsigned pick, payload_len;
        cmd = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
        issue_command(cmd);
        hdr = {1'b1, 3'($urandom), 4'h0};
        pick = $urandom_range(99);
        pkt.delete();
        if (pick < 50) begin
            if (cmd == CMD_SETPOS_ACK || cmd == CMD_ZOOM_ACK) begin
                pkt = {hdr, REPLY_ACK_BIT | 8'($urandom_range(15))};
            end else if (cmd >= CMD_GET_POSITION && cmd <= CMD_GET_MAX_SPEED) begin
                pkt = {hdr, REPLY_INQUIRY};
                payload_len = (cmd == CMD_GET_POSITION) ? 8 : (cmd == CMD_GET_ZOOM) ? 4 : 2;
                if ($urandom_range(7) == 0) payload_len = $urandom_range(payload_len);
                repeat (payload_len) pkt.push_back(($urandom_range(3) == 0) ?
                                                   8'($urandom_range(254)) :
                                                   8'($urandom_range(15)));
            end else begin
                // Cameras acknowledge before completing; a completion wait drops it.
                if ($urandom_range(1)) begin
                    pkt = {hdr, REPLY_ACK, TERMINATOR};
                    send_packet(pkt);
                end
                pkt = {hdr, $urandom_range(1) ? REPLY_DONE_A : REPLY_DONE_B};
            end
            pkt.push_back(TERMINATOR);
        end else if (pick < 62) begin
            pkt = {hdr, REPLY_ERROR, 8'($urandom_range(254)), TERMINATOR};
        end else if (pick < 74) begin
            repeat ($urandom_range(5)) pkt.push_back(8'($urandom_range(254)));
            pkt.push_back(TERMINATOR);
        end else if (pick < 82) begin
            repeat (MaxPacket - 1) pkt.push_back(8'($urandom_range(254)));
            pkt.push_back(8'($urandom));
        end else if (pick < 92) begin
            // Left unfinished; the next known command discards it.
            repeat ($urandom_range(4, 1)) pkt.push_back(8'($urandom_range(254)));
        end
        send_packet(pkt);
    endtask

    // Random traffic under four handshake mixes and a fresh address for each.
    task automatic test_random_traffic();
        int unsigned src_mix[4]  = '{0, 75, 0, 25};
        int unsigned sink_mix[4] = '{0, 0, 75, 25};
        int goal;
        for (int p = 0; p < 4; p++) begin
            write_address(3'($urandom_range(7)));
            src_idle_pct = src_mix[p];
            sink_stall_pct = sink_mix[p];
            goal = items_sent + RandomItems / 4;
            while (items_sent < goal) random_exchange();
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence and end of run.
    // ------------------------------------------------------------------

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_reply_cases();
        test_address_settings();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        $display("Run covered %0d input beats and %0d result beats: %0d replies done,",
                 items_sent, beats_checked, done_seen);
        $display("%0d camera errors, %0d overflows, addresses 0 to 7 and four idle mixes.",
                 error_seen, overflow_seen);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(TimeLimit);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/vptz_pkg.sv
rtl/vptz_tx_framer.sv
rtl/vptz_rx_parser.sv
rtl/visca_ptz_command_reply_engine_unit.sv
tb/sv/visca_ptz_command_reply_engine_unit_tb.sv
